// File: src/btlv_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the BER TLV stream decoder.
package btlv_pkg;

   localparam int MAX_LENGTH_BYTES = 4;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] TAG_INTEGER   = 8'h02;
   localparam logic [7:0] TAG_OID       = 8'h06;
   localparam logic [7:0] TAG_COUNTER   = 8'h41;
   localparam logic [7:0] TAG_GAUGE     = 8'h42;
   localparam logic [7:0] TAG_TIMETICKS = 8'h43;
   localparam logic [7:0] TAG_COUNTER64 = 8'h46;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_BYTE    = 3'd1,
      KIND_NUMBER  = 3'd2,
      KIND_ARC     = 3'd3,
      KIND_UNKNOWN = 3'd4,
      KIND_TRUNC   = 3'd5
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } btlv_req_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        tag_seen;
      logic signed [63:0] value;
      logic              item_done;
   } btlv_rsp_type;

   typedef struct packed {
      logic         two;
      btlv_rsp_type r0;
      btlv_rsp_type r1;
   } btlv_entry_type;

   typedef struct packed {
      logic           push;
      btlv_entry_type entry;
   } btlv_push_type;

   typedef struct packed {
      logic           valid;
      btlv_entry_type entry;
   } btlv_head_type;

   function automatic btlv_rsp_type make_rsp(kind_type kind, logic [7:0] tag,
                                             logic [63:0] value, logic done);
      btlv_rsp_type r;
      r.kind      = kind;
      r.tag_seen  = tag;
      r.value     = value;
      r.item_done = done;
      return r;
   endfunction

   function automatic logic known_tag(logic [7:0] t);
      logic k;
      unique case (t) inside
         8'h02, 8'h04, 8'h05, 8'h06, 8'h30,
         8'h40, 8'h41, 8'h42, 8'h43, 8'h46,
         8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4,
         8'hA5, 8'hA7, 8'h80, 8'h81, 8'h82: k = 1'b1;
         default: k = 1'b0;
      endcase
      return k;
   endfunction

   function automatic logic number_tag(logic [7:0] t);
      return t == TAG_INTEGER || t == TAG_COUNTER || t == TAG_GAUGE ||
             t == TAG_TIMETICKS || t == TAG_COUNTER64;
   endfunction

endpackage

// File: src/btlv_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks TLV phase and builds result beats.
module btlv_front import btlv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  btlv_req_type  req_payload,
   input  logic          queue_full,
   output btlv_push_type push
);

   typedef enum logic [1:0] {
      PH_TAG  = 2'd0,
      PH_LEN  = 2'd1,
      PH_LENB = 2'd2,
      PH_BODY = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  tag_ff, tag_in;
   logic [3:0]  lbl_ff, lbl_in;
   logic [31:0] left_ff, left_in;
   logic [63:0] num_ff, num_in;
   logic [31:0] arc_ff, arc_in;
   logic        first_ff, first_in;

   logic [7:0]   b;
   logic         last;
   logic         accept;
   btlv_rsp_type res0, res1;
   logic [1:0]   nres;
   logic         end_item;
   logic         hdr_fire;
   logic [31:0]  hdr_len;
   logic [31:0]  len_next;
   logic         done;
   logic [63:0]  acc_base, num_new;
   logic [31:0]  arc_new;
   logic [15:0]  prod;
   logic [2:0]   quo;
   logic [7:0]   rem;

   assign b         = req_payload.in_byte;
   assign last      = req_payload.in_last;
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // divide by 40 through reciprocal multiply
   assign prod = {8'd0, b} * 16'd205;
   assign quo  = prod[15:13];
   assign rem  = b - ({5'd0, quo} * 8'd40);

   assign len_next = (left_ff[31:24] != 8'd0) ? 32'hFFFF_FFFF : {left_ff[23:0], b};
   assign done     = (left_ff == 32'd1);
   assign acc_base = first_ff ? {64{b[7]}} : num_ff;
   assign num_new  = {acc_base[55:0], b};
   assign arc_new  = {arc_ff[24:0], b[6:0]};

   always_comb begin
      phase_in = phase_ff;
      tag_in   = tag_ff;
      lbl_in   = lbl_ff;
      left_in  = left_ff;
      num_in   = num_ff;
      arc_in   = arc_ff;
      first_in = first_ff;
      res0     = '0;
      res1     = '0;
      nres     = 2'd0;
      end_item = 1'b0;
      hdr_fire = 1'b0;
      hdr_len  = '0;
      unique case (phase_ff)
         PH_TAG: begin
            if (!known_tag(b)) begin
               res0     = make_rsp(KIND_UNKNOWN, b, 64'd0, 1'b1);
               nres     = 2'd1;
               end_item = 1'b1;
               lbl_in   = '0;
               left_in  = '0;
            end else begin
               tag_in   = b;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            if (b[7]) begin
               if (b[3:0] == 4'd0) begin
                  hdr_fire = 1'b1;
               end else begin
                  lbl_in   = b[3:0];
                  left_in  = (b[3:0] > 4'(MAX_LENGTH_BYTES)) ? 32'hFFFF_FFFF : 32'd0;
                  phase_in = PH_LENB;
               end
            end else begin
               hdr_fire = 1'b1;
               hdr_len  = {24'd0, b};
            end
         end
         PH_LENB: begin
            lbl_in = lbl_ff - 4'd1;
            if (lbl_ff == 4'd1) begin
               hdr_fire = 1'b1;
               hdr_len  = len_next;
            end else begin
               left_in = len_next;
            end
         end
         PH_BODY: begin
            left_in = left_ff - 32'd1;
            if (number_tag(tag_ff)) begin
               num_in = num_new;
               if (done) begin
                  nres = 2'd1;
                  res0 = make_rsp(KIND_NUMBER, tag_ff,
                                  (tag_ff == TAG_INTEGER) ?
                                  {{32{num_new[31]}}, num_new[31:0]} : num_new, 1'b1);
               end
            end else if (tag_ff == TAG_OID) begin
               if (first_ff) begin
                  if (done || !last) begin
                     nres = 2'd2;
                     res0 = make_rsp(KIND_ARC, tag_ff, {61'd0, quo}, 1'b0);
                     res1 = make_rsp(KIND_ARC, tag_ff, {56'd0, rem}, done);
                  end
               end else begin
                  arc_in = arc_new;
                  if (!b[7] || done) begin
                     nres   = 2'd1;
                     res0   = make_rsp(KIND_ARC, tag_ff, {32'd0, arc_new}, done);
                     arc_in = '0;
                  end
               end
            end else begin
               nres = 2'd1;
               res0 = make_rsp(KIND_BYTE, tag_ff, {56'd0, b}, done);
            end
            first_in = 1'b0;
            if (done) begin
               end_item = 1'b1;
               phase_in = PH_TAG;
               lbl_in   = '0;
               left_in  = '0;
            end
         end
         default: phase_in = PH_TAG;
      endcase

      if (hdr_fire) begin
         nres     = 2'd1;
         res0     = make_rsp(KIND_HEADER, tag_ff, {32'd0, hdr_len}, hdr_len == 32'd0);
         num_in   = '0;
         arc_in   = '0;
         first_in = 1'b1;
         left_in  = hdr_len;
         if (hdr_len == 32'd0) begin
            phase_in = PH_TAG;
            lbl_in   = '0;
         end else begin
            phase_in = PH_BODY;
         end
      end

      // flag data that ends inside an item
      if (last && !end_item && phase_in != PH_TAG) begin
         if (nres == 2'd0) begin
            res0 = make_rsp(KIND_TRUNC, tag_in, 64'd0, 1'b1);
         end else begin
            res1 = make_rsp(KIND_TRUNC, tag_in, 64'd0, 1'b1);
         end
         nres     = nres + 2'd1;
         phase_in = PH_TAG;
         lbl_in   = '0;
         left_in  = '0;
      end
   end

   always_comb begin
      push.push     = accept && (nres != 2'd0);
      push.entry.two = (nres == 2'd2);
      push.entry.r0  = res0;
      push.entry.r1  = res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         tag_ff   <= '0;
         lbl_ff   <= '0;
         left_ff  <= '0;
         num_ff   <= '0;
         arc_ff   <= '0;
         first_ff <= 1'b1;
      end else if (accept) begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         lbl_ff   <= lbl_in;
         left_ff  <= left_in;
         num_ff   <= num_in;
         arc_ff   <= arc_in;
         first_ff <= first_in;
      end
   end

endmodule

// File: src/btlv_queue.sv
`timescale 1ns / 1ps
// Short queue of result bundles between the front and back ends.
module btlv_queue import btlv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  btlv_push_type push,
   output logic          full,
   output btlv_head_type head,
   input  logic          pop
);

   btlv_entry_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in;
   logic [QUEUE_AW-1:0] rd_ff, rd_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign do_push    = push.push && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: src/btlv_back.sv
`timescale 1ns / 1ps
// Back end: splits each queued bundle into one or two result beats.
module btlv_back import btlv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  btlv_head_type head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output btlv_rsp_type  rsp_payload
);

   logic sub_ff, sub_in;
   logic accept;

   assign rsp_valid   = head.valid;
   assign rsp_payload = sub_ff ? head.entry.r1 : head.entry.r0;
   assign accept      = rsp_valid && !rsp_stall;
   assign pop         = accept && (sub_ff || !head.entry.two);
   assign sub_in      = accept ? (!sub_ff && head.entry.two) : sub_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

// File: src/ber_tlv_stream_decoder_core.sv
`timescale 1ns / 1ps
// Top level of the SNMP BER TLV stream decoder.
// Results of an accepted byte are registered in the queue, which drives the output.
// Throughput: one input beat per cycle while the queue has room; one result beat per
// cycle while rsp_stall is low. Two results of one byte share a 4-bundle queue entry.
// Reset (synchronous): decoder expects a tag, queue empties, no result beat is valid.
module ber_tlv_stream_decoder_core import btlv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  btlv_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output btlv_rsp_type rsp_payload
);

   btlv_push_type push;
   btlv_head_type head;
   logic          queue_full;
   logic          pop;

   btlv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push)
   );

   btlv_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   btlv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: src/btlv_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the decoder core, bound to the top level.
module btlv_checker import btlv_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input btlv_rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   a_terminal_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_UNKNOWN || rsp_payload.kind == KIND_TRUNC)
      |-> rsp_payload.item_done && rsp_payload.value == 64'd0)
      else $error("unknown or truncated beat malformed");

   a_empty_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_HEADER
      |-> rsp_payload.item_done == (rsp_payload.value == 64'd0))
      else $error("header done flag disagrees with length");

endmodule

bind ber_tlv_stream_decoder_core btlv_checker u_btlv_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SNMP BER TLV stream decoder core.
module tb;
   import btlv_pkg::*;

   typedef logic [7:0] byte_queue_type[$];
   typedef enum logic [1:0] {
      DEC_TAG,
      DEC_LEN,
      DEC_LEN_BYTES,
      DEC_CONTENT
   } dec_phase_type;

   localparam logic [7:0] LONG_FORM_BIT  = 8'h80;
   localparam logic [7:0] ARC_MORE_BIT   = 8'h80;
   localparam int         OID_ARC_DIV    = 40;
   localparam int         NUM_SNMP_TAGS  = 20;
   localparam int         DRAIN_LIMIT    = 50000;
   localparam int         PRINT_LIMIT    = 30;

   logic         clock;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   btlv_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   btlv_rsp_type rsp_payload;

   ber_tlv_stream_decoder_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // decoder state mirror
   dec_phase_type dec_phase        = DEC_TAG;
   logic [7:0]    dec_tag          = '0;
   logic [3:0]    dec_len_left     = '0;
   logic [31:0]   dec_content_left = '0;
   logic [63:0]   dec_number       = '0;
   logic [31:0]   dec_arc          = '0;
   logic          dec_first        = 1'b1;

   btlv_rsp_type  pending_results[$];

   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;
   int unsigned hold_off_left  = 0;
   int unsigned bytes_sent     = 0;
   int unsigned beats_checked  = 0;
   int unsigned arcs_seen      = 0;
   int unsigned numbers_seen   = 0;
   int unsigned unknown_seen   = 0;
   int unsigned trunc_seen     = 0;
   int unsigned errors         = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [7:0] tag_by_index(input int unsigned i);
      logic [7:0] t;
      case (i)
         0:  t = 8'h02;
         1:  t = 8'h04;
         2:  t = 8'h05;
         3:  t = 8'h06;
         4:  t = 8'h30;
         5:  t = 8'h40;
         6:  t = 8'h41;
         7:  t = 8'h42;
         8:  t = 8'h43;
         9:  t = 8'h46;
         10: t = 8'hA0;
         11: t = 8'hA1;
         12: t = 8'hA2;
         13: t = 8'hA3;
         14: t = 8'hA4;
         15: t = 8'hA5;
         16: t = 8'hA7;
         17: t = 8'h80;
         18: t = 8'h81;
         default: t = 8'h82;
      endcase
      return t;
   endfunction

   function automatic logic tag_is_known(input logic [7:0] t);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_SNMP_TAGS; i++)
         if (tag_by_index(i) == t) hit = 1'b1;
      return hit;
   endfunction

   function automatic logic tag_is_number(input logic [7:0] t);
      return t == TAG_INTEGER || t == TAG_COUNTER || t == TAG_GAUGE ||
             t == TAG_TIMETICKS || t == TAG_COUNTER64;
   endfunction

   task automatic expect_result(input kind_type k, input logic [7:0] t,
                                input logic [63:0] v, input logic done);
      btlv_rsp_type r;
      r.kind      = k;
      r.tag_seen  = t;
      r.value     = v;
      r.item_done = done;
      pending_results.insert(pending_results.size(), r);
   endtask

   task automatic return_to_tag();
      dec_phase        = DEC_TAG;
      dec_len_left     = '0;
      dec_content_left = '0;
   endtask

   task automatic emit_header();
      logic empty;
      empty = (dec_content_left == 32'd0);
      expect_result(KIND_HEADER, dec_tag, {32'd0, dec_content_left}, empty);
      dec_number = '0;
      dec_arc    = '0;
      dec_first  = 1'b1;
      if (empty) return_to_tag();
      else dec_phase = DEC_CONTENT;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic        done;
      logic [63:0] v;
      logic [63:0] hi_arc;
      logic [63:0] lo_arc;
      case (dec_phase)
         DEC_TAG: begin
            if (!tag_is_known(b)) begin
               expect_result(KIND_UNKNOWN, b, 64'd0, 1'b1);
               return_to_tag();
            end else begin
               dec_tag   = b;
               dec_phase = DEC_LEN;
            end
         end
         DEC_LEN: begin
            if (b & LONG_FORM_BIT) begin
               dec_content_left = (b[3:0] > MAX_LENGTH_BYTES) ? '1 : '0;
               if (b[3:0] == 4'd0) begin
                  dec_content_left = '0;
                  emit_header();
               end else begin
                  dec_len_left = b[3:0];
                  dec_phase    = DEC_LEN_BYTES;
               end
            end else begin
               dec_content_left = {24'd0, b};
               emit_header();
            end
         end
         DEC_LEN_BYTES: begin
            if (dec_content_left[31:24] != 8'd0) dec_content_left = '1;
            else dec_content_left = {dec_content_left[23:0], b};
            dec_len_left = dec_len_left - 4'd1;
            if (dec_len_left == 4'd0) emit_header();
         end
         default: begin
            dec_content_left = dec_content_left - 32'd1;
            done = (dec_content_left == 32'd0);
            if (tag_is_number(dec_tag)) begin
               if (dec_first) dec_number = b[7] ? '1 : '0;
               dec_number = {dec_number[55:0], b};
               if (done) begin
                  v = dec_number;
                  if (dec_tag == TAG_INTEGER) v = {{32{dec_number[31]}}, dec_number[31:0]};
                  expect_result(KIND_NUMBER, dec_tag, v, 1'b1);
               end
            end else if (dec_tag == TAG_OID) begin
               if (dec_first) begin
                  if (done || !last) begin
                     hi_arc = 64'(b / OID_ARC_DIV);
                     lo_arc = 64'(b % OID_ARC_DIV);
                     expect_result(KIND_ARC, dec_tag, hi_arc, 1'b0);
                     expect_result(KIND_ARC, dec_tag, lo_arc, done);
                  end
               end else begin
                  dec_arc = {dec_arc[24:0], b[6:0]};
                  if (!(b & ARC_MORE_BIT) || done) begin
                     expect_result(KIND_ARC, dec_tag, {32'd0, dec_arc}, done);
                     dec_arc = '0;
                  end
               end
            end else begin
               expect_result(KIND_BYTE, dec_tag, {56'd0, b}, done);
            end
            dec_first = 1'b0;
            if (done) return_to_tag();
         end
      endcase
      if (last && dec_phase != DEC_TAG) begin
         expect_result(KIND_TRUNC, dec_tag, 64'd0, 1'b1);
         return_to_tag();
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (errors < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      btlv_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d tag %h value %h",
                                      rsp_payload.kind, rsp_payload.tag_seen,
                                      rsp_payload.value));
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.kind !== want.kind)
               report_mismatch($sformatf("beat %0d kind %0d, want %0d",
                                         beats_checked, rsp_payload.kind, want.kind));
            if (rsp_payload.tag_seen !== want.tag_seen)
               report_mismatch($sformatf("beat %0d tag %h, want %h",
                                         beats_checked, rsp_payload.tag_seen, want.tag_seen));
            if (rsp_payload.value !== want.value)
               report_mismatch($sformatf("beat %0d value %h, want %h",
                                         beats_checked, rsp_payload.value, want.value));
            if (rsp_payload.item_done !== want.item_done)
               report_mismatch($sformatf("beat %0d item_done %b, want %b",
                                         beats_checked, rsp_payload.item_done,
                                         want.item_done));
            case (want.kind)
               KIND_ARC:     arcs_seen++;
               KIND_NUMBER:  numbers_seen++;
               KIND_UNKNOWN: unknown_seen++;
               KIND_TRUNC:   trunc_seen++;
               default: ;
            endcase
         end
         beats_checked++;
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic last);
      btlv_req_type beat;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      beat.in_byte = b;
      beat.in_last = last;
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_bytes(input byte_queue_type q, input logic end_last);
      foreach (q[i]) send_beat(q[i], end_last && (i == q.size() - 1));
   endtask

   task automatic wait_for_results();
      int unsigned n;
      req_valid <= 1'b0;
      @(posedge clock);
      n = 0;
      while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (pending_results.size() != 0) begin
         report_mismatch($sformatf("%0d expected beats never arrived",
                                   pending_results.size()));
         pending_results.delete();
      end
   endtask

   task automatic send_random_item();
      byte_queue_type q;
      logic [7:0]  tag;
      logic [2:0]  junk;
      logic [3:0]  cnt;
      int unsigned len;
      int unsigned n;
      int unsigned r;
      int unsigned cut;
      logic        endless;
      endless = 1'b0;
      if ($urandom_range(99, 0) < 8) begin
         n = $urandom_range(3, 1);
         for (int i = 0; i < n; i++) q.insert(q.size(), 8'($urandom_range(255, 0)));
         send_bytes(q, 1'b1);
         return;
      end
      tag  = tag_by_index($urandom_range(NUM_SNMP_TAGS - 1, 0));
      len  = tag_is_number(tag) ? $urandom_range(9, 0) : $urandom_range(12, 0);
      junk = 3'($urandom_range(7, 0));
      q.insert(q.size(), tag);
      case ($urandom_range(9, 0))
         7: begin
            if (len == 0) begin
               q.insert(q.size(), {1'b1, junk, 4'h0});
            end else begin
               q.insert(q.size(), {1'b1, junk, 4'h1});
               q.insert(q.size(), 8'(len));
            end
         end
         8: begin
            cnt = 4'($urandom_range(MAX_LENGTH_BYTES, 2));
            q.insert(q.size(), {1'b1, junk, cnt});
            for (int i = 1; i < cnt; i++) q.insert(q.size(), 8'h00);
            q.insert(q.size(), 8'(len));
         end
         9: begin
            cnt = 4'($urandom_range(15, MAX_LENGTH_BYTES + 1));
            q.insert(q.size(), {1'b1, junk, cnt});
            for (int i = 0; i < cnt; i++) q.insert(q.size(), 8'($urandom_range(255, 0)));
            len     = $urandom_range(6, 0);
            endless = 1'b1;
         end
         default: q.insert(q.size(), 8'(len));
      endcase
      for (int i = 0; i < len; i++) q.insert(q.size(), 8'($urandom_range(255, 0)));
      r = $urandom_range(99, 0);
      if (endless) begin
         send_bytes(q, 1'b1);
      end else if (r < 6) begin
         cut = $urandom_range(q.size() - 2, 0);
         while (q.size() > cut + 1) q.delete(q.size() - 1);
         send_bytes(q, 1'b1);
      end else begin
         send_bytes(q, r >= 94);
      end
   endtask

   task automatic test_unknown_tags();
      byte_queue_type q;
      q = '{8'h00};
      send_bytes(q, 1'b0);
      q = '{8'hA6};
      send_bytes(q, 1'b1);
   endtask

   task automatic test_numbers();
      byte_queue_type q;
      q = '{8'h02, 8'h01, 8'h80};
      send_bytes(q, 1'b0);
      q = '{8'h02, 8'h05, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_bytes(q, 1'b0);
      q = '{8'h41, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_bytes(q, 1'b0);
      q = '{8'h46, 8'h09, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09};
      send_bytes(q, 1'b0);
      q = '{8'h05, 8'h00};
      send_bytes(q, 1'b0);
   endtask

   task automatic test_oid();
      byte_queue_type q;
      q = '{8'h06, 8'h03, 8'h2B, 8'h06, 8'h01};
      send_bytes(q, 1'b0);
      q = '{8'h06, 8'h02, 8'h2B, 8'h86};
      send_bytes(q, 1'b0);
      q = '{8'h06, 8'h07, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
      send_bytes(q, 1'b0);
   endtask

   task automatic test_lengths();
      byte_queue_type q;
      q = '{8'h04, 8'h81, 8'h02, 8'hAA, 8'hBB};
      send_bytes(q, 1'b0);
      q = '{8'h04, 8'hF1, 8'h01, 8'hCC};
      send_bytes(q, 1'b0);
      q = '{8'h04, 8'h80};
      send_bytes(q, 1'b0);
      q = '{8'h04, 8'h85, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hAA, 8'hBB};
      send_bytes(q, 1'b1);
   endtask

   task automatic test_truncation();
      byte_queue_type q;
      q = '{8'h30};
      send_bytes(q, 1'b1);
      q = '{8'h02, 8'h04, 8'h01, 8'h02};
      send_bytes(q, 1'b1);
      q = '{8'h06, 8'h03, 8'h2B};
      send_bytes(q, 1'b1);
      q = '{8'h06, 8'h01, 8'h2B};
      send_bytes(q, 1'b1);
   endtask

   task automatic test_passthrough();
      byte_queue_type q;
      q = '{8'h30, 8'h03, 8'h02, 8'h01, 8'h05};
      send_bytes(q, 1'b0);
      q = '{8'hA2, 8'h02, 8'h00, 8'hFF};
      send_bytes(q, 1'b0);
      q = '{8'h40, 8'h04, 8'hC0, 8'hA8, 8'h00, 8'h01};
      send_bytes(q, 1'b0);
   endtask

   task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned n_bytes);
      int unsigned start;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) send_random_item();
      wait_for_results();
   endtask

   task automatic test_backpressure();
      int unsigned start;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_left = 200;
      start = bytes_sent;
      while (bytes_sent - start < 80) send_random_item();
      wait_for_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_unknown_tags();
      test_numbers();
      test_oid();
      test_lengths();
      test_truncation();
      test_passthrough();
      wait_for_results();
      test_random_traffic(0, 0, 240);
      test_random_traffic(77, 0, 240);
      test_random_traffic(0, 77, 240);
      test_random_traffic(14, 14, 240);
      test_backpressure();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d expected beats left over", pending_results.size()));
      $display("Sent %0d bytes; checked %0d result beats (%0d numbers, %0d oid arcs).",
               bytes_sent, beats_checked, numbers_seen, arcs_seen);
      $display("Saw %0d unknown tags and %0d early ends across all idle and stall phases.",
               unknown_seen, trunc_seen);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: sim.f
src/btlv_pkg.sv
src/btlv_front.sv
src/btlv_queue.sv
src/btlv_back.sv
src/ber_tlv_stream_decoder_core.sv
src/btlv_checker.sv
tb/tb.sv
